FILE: design/i2cm_pkg.sv
// Shared types, codes and the phase entry helper for the I2C master bit engine.
// Used by i2cm_step.sv and i2c_master_bit_engine.sv; depends on nothing.

package i2cm_pkg;

  localparam int unsigned DelayW = 16;
  localparam logic [DelayW-1:0] DELAY_RESET = 16'd100;
  localparam int unsigned InDataW = 16;
  localparam int unsigned OutDataW = 16;
  localparam logic [3:0] BITS_PER_BYTE = 4'd8;
  localparam logic [3:0] BITS_PER_ACK = 4'd1;
  localparam logic [7:0] NACK_PATTERN = 8'h80;

  typedef enum logic [2:0] {
    OP_START  = 3'd0,
    OP_STOP   = 3'd1,
    OP_WRITE  = 3'd2,
    OP_READ   = 3'd3,
    OP_GETACK = 3'd4,
    OP_PUTACK = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_SETUP = 2'd1,
    PH_HOLD  = 2'd2,
    PH_HIGH  = 2'd3
  } phase_t;

  typedef struct packed {
    logic       cmd_valid;
    logic [2:0] operation;
    logic [7:0] tx_byte;
    logic       ack_to_send;
    logic       sda_in;
  } item_t;

  typedef struct packed {
    op_t              op;
    phase_t           phase;
    logic [3:0]       bit_count;
    logic [DelayW-1:0] delay_count;
    logic [7:0]       tx_shift;
    logic [7:0]       rx_shift;
    logic             scl;
    logic             sda;
    logic             ack;
    logic             busy;
  } state_t;

  function automatic state_t enter_phase(input state_t s, input phase_t ph, input logic sda,
                                         input logic [DelayW-1:0] load);
    state_t r;
    r = s;
    r.phase = ph;
    r.delay_count = load;
    case (s.op)
      OP_START: begin
        r.scl = 1'b1;
        r.sda = (ph == PH_SETUP);
      end
      OP_STOP: begin
        r.scl = 1'b1;
        r.sda = (ph != PH_SETUP);
      end
      default: begin
        if (ph == PH_SETUP) begin
          r.scl = 1'b0;
          if (s.op == OP_WRITE || s.op == OP_PUTACK) begin
            r.sda = s.tx_shift[7];
            r.tx_shift = {s.tx_shift[6:0], 1'b0};
          end else begin
            r.sda = 1'b1;
          end
        end else if (ph == PH_HIGH) begin
          r.scl = 1'b1;
          if (s.op == OP_READ) begin
            r.rx_shift = {s.rx_shift[6:0], sda};
          end else if (s.op == OP_GETACK) begin
            r.ack = sda;
          end
        end
      end
    endcase
    return r;
  endfunction

endpackage

FILE: design/i2c_master_bit_engine.sv
// Top level of the I2C master bit engine: input register, state register and result register.
// Depends on i2cm_pkg and i2cm_step.
//
// Channel  Direction  Contents
// in_      slave      one tick: command valid, operation, byte, ack level, sampled SDA
// out_     master     one result per tick: SCL, SDA, busy, done, received byte, ack missing
// cfg_     write      delay unit length in ticks
//
// A tick may be accepted in every cycle while the result is not stalled.
// A tick's result passes through the input register and then the result register, from which it is offered.
// Synchronous active-low reset releases both lines, clears the state and sets the delay to 100.
// A stalled result holds the state step; input is taken while the input register can move on.

module i2c_master_bit_engine (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // [0] cmd_valid, [3:1] operation, [11:4] tx_byte, [12] ack_to_send, [13] sda_in
  input  logic [i2cm_pkg::InDataW-1:0]  in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // [0] scl, [1] sda_out, [2] busy_res, [3] done_res, [11:4] rx_byte, [12] ack_missing
  output logic [i2cm_pkg::OutDataW-1:0] out_tdata,
  input  logic                          cfg_we,
  input  logic [i2cm_pkg::DelayW-1:0]   cfg_wdata
);

  logic                          in_valid_r;
  i2cm_pkg::item_t               in_item_r;
  i2cm_pkg::item_t               in_item_nxt;
  logic                          out_valid_r;
  logic [i2cm_pkg::OutDataW-1:0] out_data_r;
  logic [i2cm_pkg::OutDataW-1:0] out_data_nxt;
  logic [i2cm_pkg::DelayW-1:0]   delay_ticks_r;
  i2cm_pkg::state_t              state_r;
  i2cm_pkg::state_t              state_nxt;
  logic                          step_done;
  logic                          advance;
  logic                          fire;

  assign advance = !out_valid_r || out_tready;
  assign fire = in_valid_r && advance;
  assign in_tready = !in_valid_r || advance;

  assign in_item_nxt.cmd_valid = in_tdata[0];
  assign in_item_nxt.operation = in_tdata[3:1];
  assign in_item_nxt.tx_byte = in_tdata[11:4];
  assign in_item_nxt.ack_to_send = in_tdata[12];
  assign in_item_nxt.sda_in = in_tdata[13];

  i2cm_step u_step (
    .cur         (state_r),
    .item        (in_item_r),
    .delay_ticks (delay_ticks_r),
    .nxt         (state_nxt),
    .done        (step_done)
  );

  assign out_data_nxt = {3'b000, state_nxt.ack, state_nxt.rx_shift, step_done,
                         state_nxt.busy, state_nxt.sda, state_nxt.scl};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_item_r <= in_item_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_ticks_r <= i2cm_pkg::DELAY_RESET;
    end else if (cfg_we) begin
      delay_ticks_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.op <= i2cm_pkg::OP_START;
      state_r.phase <= i2cm_pkg::PH_IDLE;
      state_r.bit_count <= '0;
      state_r.delay_count <= '0;
      state_r.tx_shift <= '0;
      state_r.rx_shift <= '0;
      state_r.scl <= 1'b1;
      state_r.sda <= 1'b1;
      state_r.ack <= 1'b0;
      state_r.busy <= 1'b0;
    end else if (fire) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = out_data_r;

  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    !state_r.busy |-> (state_r.phase == i2cm_pkg::PH_IDLE && state_r.delay_count == '0))
    else $error("idle engine holds a phase or delay count");

  a_busy_phase: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.busy |-> state_r.phase != i2cm_pkg::PH_IDLE)
    else $error("busy engine in idle phase");

  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_data_r[3] && out_data_r[2]))
    else $error("result reports done and busy together");

  a_stall_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |=> $stable(state_r))
    else $error("state stepped while the result was stalled");

endmodule

FILE: design/i2cm_step.sv
// One-tick update of the bit engine state: command acceptance, delay count and phase steps.
// Depends on i2cm_pkg.

module i2cm_step (
  input  i2cm_pkg::state_t              cur,
  input  i2cm_pkg::item_t               item,
  input  logic [i2cm_pkg::DelayW-1:0]   delay_ticks,
  output i2cm_pkg::state_t              nxt,
  output logic                          done
);

  logic [i2cm_pkg::DelayW-1:0] load;
  logic [3:0]                  bits_left;
  i2cm_pkg::state_t            fin;
  i2cm_pkg::state_t            acc;

  assign load = (delay_ticks == '0) ? '0 : delay_ticks - 1'b1;
  assign bits_left = cur.bit_count - 1'b1;

  always_comb begin
    fin = cur;
    if (cur.op != i2cm_pkg::OP_STOP) begin
      fin.scl = 1'b0;
    end
    fin.busy = 1'b0;
    fin.phase = i2cm_pkg::PH_IDLE;
    fin.delay_count = '0;
  end

  always_comb begin
    acc = cur;
    acc.op = i2cm_pkg::op_t'(item.operation);
    acc.busy = 1'b1;
    acc.bit_count = (acc.op == i2cm_pkg::OP_WRITE || acc.op == i2cm_pkg::OP_READ) ?
                    i2cm_pkg::BITS_PER_BYTE : i2cm_pkg::BITS_PER_ACK;
    if (acc.op == i2cm_pkg::OP_WRITE) begin
      acc.tx_shift = item.tx_byte;
    end else if (acc.op == i2cm_pkg::OP_PUTACK) begin
      acc.tx_shift = item.ack_to_send ? i2cm_pkg::NACK_PATTERN : 8'h00;
    end
  end

  always_comb begin
    nxt = cur;
    done = 1'b0;
    if (!cur.busy) begin
      if (item.cmd_valid && item.operation <= i2cm_pkg::OP_PUTACK) begin
        nxt = i2cm_pkg::enter_phase(acc, i2cm_pkg::PH_SETUP, item.sda_in, load);
      end
    end else if (cur.delay_count != '0) begin
      nxt.delay_count = cur.delay_count - 1'b1;
    end else if (cur.op == i2cm_pkg::OP_START) begin
      if (cur.phase == i2cm_pkg::PH_SETUP) begin
        nxt = i2cm_pkg::enter_phase(cur, i2cm_pkg::PH_HOLD, item.sda_in, load);
      end else begin
        nxt = fin;
        done = 1'b1;
      end
    end else begin
      case (cur.phase)
        i2cm_pkg::PH_IDLE: begin
          nxt = i2cm_pkg::enter_phase(cur, i2cm_pkg::PH_SETUP, item.sda_in, load);
        end
        i2cm_pkg::PH_SETUP: begin
          nxt = i2cm_pkg::enter_phase(cur, i2cm_pkg::PH_HOLD, item.sda_in, load);
        end
        i2cm_pkg::PH_HOLD: begin
          nxt = i2cm_pkg::enter_phase(cur, i2cm_pkg::PH_HIGH, item.sda_in, load);
        end
        default: begin
          if (cur.op == i2cm_pkg::OP_STOP) begin
            nxt = fin;
            done = 1'b1;
          end else if (bits_left == '0) begin
            nxt = fin;
            nxt.bit_count = bits_left;
            done = 1'b1;
          end else begin
            nxt.bit_count = bits_left;
            nxt = i2cm_pkg::enter_phase(nxt, i2cm_pkg::PH_SETUP, item.sda_in, load);
          end
        end
      endcase
    end
  end

endmodule

FILE: bench/i2c_master_bit_engine_check.sv
`timescale 1ns / 1ps
// Prediction and checking for the I2C master bit engine: follows every accepted tick and
// compares each result transaction with the output fields it predicts. Depends on i2cm_pkg.

module i2c_master_bit_engine_check
  import i2cm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  output logic        eng_busy,
  output int          pending,
  output int          mismatches,
  output int          checked
);

  typedef struct packed {
    op_t         op;
    phase_t      ph;
    logic [3:0]  bits_left;
    logic [15:0] wait_cnt;
    logic [7:0]  tx_sr;
    logic [7:0]  rx_sr;
    logic        scl;
    logic        sda;
    logic        ack;
    logic        busy;
    logic        done;
  } eng_t;

  // Same bit order as out_tdata[12:0].
  typedef struct packed {
    logic       ack;
    logic [7:0] rx;
    logic       done;
    logic       busy;
    logic       sda;
    logic       scl;
  } lines_t;

  eng_t        eng;
  logic [15:0] unit_len;
  lines_t      expected_lines[$];

  function automatic eng_t enter_step(eng_t s, phase_t ph, logic sda_s, logic [15:0] dly);
    eng_t r;
    r = s;
    r.ph = ph;
    r.wait_cnt = ((dly == 16'd0) ? 16'd1 : dly) - 16'd1;
    if (r.op == OP_START || r.op == OP_STOP) begin
      r.scl = 1'b1;
      r.sda = (ph == PH_SETUP) ^ (r.op == OP_STOP);
    end else if (ph == PH_SETUP) begin
      r.scl = 1'b0;
      if (r.op == OP_WRITE || r.op == OP_PUTACK) begin
        r.sda = r.tx_sr[7];
        r.tx_sr = {r.tx_sr[6:0], 1'b0};
      end else begin
        r.sda = 1'b1;
      end
    end else if (ph == PH_HIGH) begin
      r.scl = 1'b1;
      if (r.op == OP_READ) begin
        r.rx_sr = {r.rx_sr[6:0], sda_s};
      end else if (r.op == OP_GETACK) begin
        r.ack = sda_s;
      end
    end
    return r;
  endfunction

  function automatic eng_t wrap_up(eng_t s);
    if (s.op != OP_STOP) begin
      s.scl = 1'b0;
    end
    s.busy = 1'b0;
    s.ph = PH_IDLE;
    s.wait_cnt = '0;
    s.done = 1'b1;
    return s;
  endfunction

  function automatic eng_t tick_engine(eng_t s, logic [15:0] dly, logic [15:0] item);
    logic       v;
    logic [2:0] opc;
    logic       s_in;
    eng_t       r;
    v = item[0];
    opc = item[3:1];
    s_in = item[13];
    r = s;
    r.done = 1'b0;
    if (!r.busy) begin
      if (v && opc <= OP_PUTACK) begin
        r.op = op_t'(opc);
        r.busy = 1'b1;
        r.bits_left = (r.op == OP_WRITE || r.op == OP_READ) ? BITS_PER_BYTE : BITS_PER_ACK;
        if (r.op == OP_WRITE) begin
          r.tx_sr = item[11:4];
        end else if (r.op == OP_PUTACK) begin
          r.tx_sr = item[12] ? NACK_PATTERN : 8'h00;
        end
        r = enter_step(r, PH_SETUP, s_in, dly);
      end
    end else if (r.wait_cnt != 16'd0) begin
      r.wait_cnt = r.wait_cnt - 16'd1;
    end else if (r.op == OP_START) begin
      if (r.ph == PH_SETUP) begin
        r = enter_step(r, PH_HOLD, s_in, dly);
      end else begin
        r = wrap_up(r);
      end
    end else if (r.ph == PH_SETUP) begin
      r = enter_step(r, PH_HOLD, s_in, dly);
    end else if (r.ph == PH_HOLD) begin
      r = enter_step(r, PH_HIGH, s_in, dly);
    end else if (r.op == OP_STOP) begin
      r = wrap_up(r);
    end else begin
      r.bits_left = r.bits_left - 4'd1;
      if (r.bits_left == 4'd0) begin
        r = wrap_up(r);
      end else begin
        r = enter_step(r, PH_SETUP, s_in, dly);
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    lines_t want;
    lines_t got;
    if (!rst_n) begin
      eng = '0;
      eng.scl = 1'b1;
      eng.sda = 1'b1;
      unit_len = DELAY_RESET;
      expected_lines.delete();
      mismatches = 0;
      checked = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = lines_t'(out_tdata[12:0]);
        if (expected_lines.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: result %h arrived with nothing expected", $realtime, out_tdata);
          end
        end else begin
          want = expected_lines.pop_front();
          checked++;
          if (got != want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: expected scl %b sda %b busy %b done %b rx %h ack %b", $realtime,
                       want.scl, want.sda, want.busy, want.done, want.rx, want.ack);
              $display("%0t: actual   scl %b sda %b busy %b done %b rx %h ack %b", $realtime,
                       got.scl, got.sda, got.busy, got.done, got.rx, got.ack);
            end
          end
        end
      end
      if (in_tvalid && in_tready) begin
        eng = tick_engine(eng, unit_len, in_tdata);
        expected_lines.push_back({eng.ack, eng.rx_sr, eng.done, eng.busy, eng.sda, eng.scl});
      end
      if (cfg_we) begin
        unit_len = cfg_wdata;
      end
    end
    eng_busy = eng.busy;
    pending = expected_lines.size();
  end

endmodule

FILE: bench/i2c_master_bit_engine_tb.sv
`timescale 1ns / 1ps
// Top of the I2C master bit engine testbench: clock, reset, tick stimulus, result stalls and
// the verdict. Depends on i2cm_pkg, i2c_master_bit_engine and i2c_master_bit_engine_check.

module i2c_master_bit_engine_tb;
  import i2cm_pkg::*;

  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;
  localparam int SDA_LOW = 0;
  localparam int SDA_HIGH = 1;
  localparam int SDA_RAND = 2;
  localparam int RX_FREE = 0;
  localparam int RX_COIN = 1;
  localparam int RX_MOSTLY = 2;
  localparam int RX_BURSTY = 3;
  localparam int STALL_LIMIT = 2000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic        tick_taken = 1'b0;
  logic        eng_busy;
  int          pending;
  int          mismatches;
  int          checked;
  int          burst_left = 0;
  int          ticks_sent = 0;
  int          cmds_sent = 0;
  int          idle_cycles = 0;
  int          rx_mode = RX_FREE;
  int          rx_mode_left = 0;
  int          rx_hold = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  i2c_master_bit_engine dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  i2c_master_bit_engine_check u_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .eng_busy  (eng_busy),
    .pending   (pending),
    .mismatches(mismatches),
    .checked   (checked)
  );

  always @(posedge clk) begin
    tick_taken <= in_tvalid && in_tready;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("No transaction for %0d cycles, %0d results outstanding", idle_cycles, pending);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  always @(negedge clk) begin
    if (rx_mode_left == 0) begin
      rx_mode = $urandom_range(RX_FREE, RX_BURSTY);
      rx_mode_left = $urandom_range(50, 400);
    end
    rx_mode_left--;
    case (rx_mode)
      RX_FREE: begin
        out_tready <= 1'b1;
      end
      RX_COIN: begin
        out_tready <= 1'($urandom_range(0, 1));
      end
      RX_MOSTLY: begin
        out_tready <= ($urandom_range(0, 3) != 0);
      end
      default: begin
        if (rx_hold > 0) begin
          rx_hold--;
          out_tready <= 1'b0;
        end else begin
          out_tready <= 1'b1;
          if ($urandom_range(0, 15) == 0) begin
            rx_hold = $urandom_range(1, 24);
          end
        end
      end
    endcase
  end

  function automatic logic coin();
    return 1'($urandom_range(0, 1));
  endfunction

  function automatic logic sda_pick(int mode);
    if (mode == SDA_LOW) begin
      return 1'b0;
    end
    if (mode == SDA_HIGH) begin
      return 1'b1;
    end
    return coin();
  endfunction

  task automatic send_tick(logic v, logic [2:0] op, logic [7:0] b, logic a, logic s);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 30);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {2'b00, s, a, b, op, v};
    do @(negedge clk); while (!tick_taken);
    burst_left--;
    ticks_sent++;
  endtask

  task automatic idle_tick(int mode);
    send_tick(1'b0, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)), coin(), sda_pick(mode));
  endtask

  // In eager mode every tick while the engine is busy offers a command, the finishing tick too.
  task automatic run_cmd(logic [2:0] op, logic [7:0] b, logic a, int mode, logic eager);
    while (eng_busy) idle_tick(mode);
    send_tick(1'b1, op, b, a, sda_pick(mode));
    cmds_sent++;
    while (eng_busy) begin
      send_tick(eager || ($urandom_range(0, 7) == 0), 3'($urandom_range(0, 7)),
                8'($urandom_range(0, 255)), coin(), sda_pick(mode));
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk);
    @(negedge clk);
  endtask

  task automatic set_delay(logic [15:0] d);
    while (eng_busy) idle_tick(SDA_RAND);
    drain();
    repeat (4) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= d;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_traffic(int goal);
    int stop_at;
    int n;
    int k;
    stop_at = ticks_sent + goal;
    while (ticks_sent < stop_at) begin
      if ($urandom_range(0, 9) < 8) begin
        run_cmd(OP_START, 8'($urandom_range(0, 255)), coin(), SDA_RAND, coin());
        run_cmd(OP_WRITE, 8'($urandom_range(0, 255)), coin(), SDA_RAND, coin());
        run_cmd(OP_GETACK, 8'($urandom_range(0, 255)), coin(), $urandom_range(0, 2), coin());
        n = $urandom_range(0, 3);
        for (k = 0; k < n; k++) begin
          if (coin()) begin
            run_cmd(OP_WRITE, 8'($urandom_range(0, 255)), coin(), SDA_RAND, coin());
            run_cmd(OP_GETACK, 8'h00, coin(), $urandom_range(0, 2), coin());
          end else begin
            run_cmd(OP_READ, 8'($urandom_range(0, 255)), coin(), SDA_RAND, coin());
            run_cmd(OP_PUTACK, 8'($urandom_range(0, 255)), coin(), SDA_RAND, coin());
          end
        end
        run_cmd(OP_STOP, 8'($urandom_range(0, 255)), coin(), SDA_RAND, coin());
      end else begin
        run_cmd(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)), coin(), SDA_RAND, coin());
      end
      repeat ($urandom_range(0, 3)) idle_tick(SDA_RAND);
      if ($urandom_range(0, 11) == 0) begin
        drain();
      end
    end
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // A start at the reset delay unit, then directed commands at the shortest unit.
    run_cmd(OP_START, 8'h00, 1'b0, SDA_RAND, 1'b0);
    set_delay(16'd1);
    run_cmd(OP_START, 8'h00, 1'b0, SDA_RAND, 1'b0);
    run_cmd(OP_WRITE, 8'h00, 1'b0, SDA_RAND, 1'b0);
    run_cmd(OP_GETACK, 8'h00, 1'b0, SDA_LOW, 1'b0);
    run_cmd(OP_WRITE, 8'hFF, 1'b1, SDA_RAND, 1'b0);
    run_cmd(OP_GETACK, 8'hFF, 1'b1, SDA_HIGH, 1'b0);
    run_cmd(OP_WRITE, 8'hA5, 1'b0, SDA_RAND, 1'b1);
    run_cmd(OP_READ, 8'h00, 1'b0, SDA_HIGH, 1'b0);
    run_cmd(OP_PUTACK, 8'h00, 1'b0, SDA_RAND, 1'b0);
    run_cmd(OP_READ, 8'hFF, 1'b1, SDA_LOW, 1'b0);
    run_cmd(OP_PUTACK, 8'hFF, 1'b1, SDA_RAND, 1'b1);
    run_cmd(OP_READ, 8'h5A, 1'b0, SDA_RAND, 1'b1);
    run_cmd(OP_SPARE6, 8'hFF, 1'b1, SDA_RAND, 1'b0);
    run_cmd(OP_SPARE7, 8'h00, 1'b0, SDA_RAND, 1'b0);
    run_cmd(OP_STOP, 8'h00, 1'b0, SDA_RAND, 1'b0);
    run_cmd(OP_STOP, 8'h00, 1'b0, SDA_RAND, 1'b1);
    run_cmd(OP_START, 8'h00, 1'b0, SDA_RAND, 1'b1);
    run_cmd(OP_PUTACK, 8'h00, 1'b1, SDA_RAND, 1'b0);
    run_cmd(OP_GETACK, 8'h00, 1'b0, SDA_RAND, 1'b1);
    run_cmd(OP_STOP, 8'h00, 1'b0, SDA_RAND, 1'b0);

    set_delay(16'd0);
    random_traffic(200);
    set_delay(16'd1);
    random_traffic(300);
    set_delay(16'd2);
    random_traffic(180);
    set_delay(16'd3);
    random_traffic(150);
    set_delay(16'd20);
    run_cmd(OP_START, 8'h00, 1'b0, SDA_RAND, 1'b0);
    set_delay(16'd1);
    run_cmd(OP_STOP, 8'h00, 1'b0, SDA_RAND, 1'b0);

    drain();
    repeat (8) @(negedge clk);
    $display("Sent %0d ticks carrying %0d commands at delay units 100, 1, 0, 2, 3 and 20.",
             ticks_sent, cmds_sent);
    $display("Checked %0d results: %0d mismatches, %0d still outstanding.",
             checked, mismatches, pending);
    if (mismatches == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
